// ===== hw/rtl/fifo_with_move_to_front_top_macros.svh =====
// assertion helpers, sampled on i_clk and quiet while i_rst_n is low
`ifndef FIFO_WITH_MOVE_TO_FRONT_TOP_MACROS_SVH
`define FIFO_WITH_MOVE_TO_FRONT_TOP_MACROS_SVH

// same-cycle implication
`define FMTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FMTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fmtf_pkg.sv =====
`timescale 1ns / 1ps

package fmtf_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
    localparam logic [OP_W-1:0] OP_MTF = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // index counter moves; the memory read address is the next index
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_ONE,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ENQ,
        WR_DN,
        WR_UP,
        WR_FRONT
    } t_wr_op;

    typedef struct packed {
        logic                cap;
        t_idx_op             idx_op;
        t_wr_op              wr_op;
        logic                occ_dec;
        logic                load_out;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            one;
        logic            match;
        logic            idx_zero;
        logic            idx_last;
    } t_sts;

endpackage

// ===== hw/rtl/fmtf_in_if.sv =====
`timescale 1ns / 1ps

interface fmtf_in_if;
    logic                                valid;
    logic                                ready;
    logic        [fmtf_pkg::OP_W-1:0]    op;
    logic signed [fmtf_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

// ===== hw/rtl/fmtf_out_if.sv =====
`timescale 1ns / 1ps

interface fmtf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fmtf_pkg::VALUE_W-1:0]  front_value;
    logic        [fmtf_pkg::COUNT_W-1:0]  count;
    logic                                 is_empty;
    logic        [fmtf_pkg::STATUS_W-1:0] status;

    modport source (output valid, output front_value, output count, output is_empty,
                    output status, input ready);
    modport sink (input valid, input front_value, input count, input is_empty,
                  input status, output ready);
endinterface

// ===== hw/rtl/fmtf_dp.sv =====
`timescale 1ns / 1ps

module fmtf_dp #(
    parameter int DEPTH      = fmtf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fmtf_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic        [fmtf_pkg::OP_W-1:0]      i_op,
    input  logic signed [fmtf_pkg::VALUE_W-1:0]   i_value,
    input  fmtf_pkg::t_cmd                        i_cmd,
    output fmtf_pkg::t_sts                        o_sts,
    output logic signed [fmtf_pkg::VALUE_W-1:0]   o_front_value,
    output logic        [fmtf_pkg::COUNT_W-1:0]   o_count,
    output logic                                  o_is_empty,
    output logic        [fmtf_pkg::STATUS_W-1:0]  o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [DATA_WIDTH-1:0] r_key;
    logic [DATA_WIDTH-1:0] r_front;
    logic [fmtf_pkg::OP_W-1:0] r_op;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic [CW-1:0] r_occ;
    logic [CW-1:0] n_occ;

    logic signed [fmtf_pkg::VALUE_W-1:0]  r_res_front;
    logic        [fmtf_pkg::COUNT_W-1:0]  r_res_count;
    logic                                 r_res_empty;
    logic        [fmtf_pkg::STATUS_W-1:0] r_res_status;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [63:0]           value_w;
    logic [63:0]           front_w;
    logic [15:0]           occ_w;

    assign value_w = 64'($unsigned(i_value));
    assign front_w = 64'(r_front);
    assign occ_w   = 16'(r_occ);

    always_comb begin
        case (i_cmd.idx_op)
            fmtf_pkg::IDX_ZERO: n_idx = '0;
            fmtf_pkg::IDX_ONE:  n_idx = AW'(1);
            fmtf_pkg::IDX_INC:  n_idx = r_idx + AW'(1);
            fmtf_pkg::IDX_DEC:  n_idx = r_idx - AW'(1);
            default:            n_idx = r_idx;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_key;
        case (i_cmd.wr_op)
            fmtf_pkg::WR_ENQ: begin
                wr_en   = 1'b1;
                wr_addr = r_occ[AW-1:0];
            end
            fmtf_pkg::WR_DN: begin
                wr_en   = 1'b1;
                wr_addr = r_idx - AW'(1);
                wr_data = r_rd_data;
            end
            fmtf_pkg::WR_UP: begin
                wr_en   = 1'b1;
                wr_addr = r_idx + AW'(1);
                wr_data = r_rd_data;
            end
            fmtf_pkg::WR_FRONT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_occ = r_occ;
        if (i_cmd.wr_op == fmtf_pkg::WR_ENQ) begin
            n_occ = r_occ + CW'(1);
        end else if (i_cmd.occ_dec) begin
            n_occ = r_occ - CW'(1);
        end
    end

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[n_idx];
    end

    // copy of the front entry, kept in step with writes to position zero
    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == '0) begin
            r_front <= wr_data;
        end
        if (i_cmd.cap) begin
            r_key <= value_w[DATA_WIDTH-1:0];
        end
        if (i_cmd.load_out) begin
            r_res_front  <= (r_occ != '0) ? front_w[fmtf_pkg::VALUE_W-1:0] : '0;
            r_res_count  <= occ_w[fmtf_pkg::COUNT_W-1:0];
            r_res_empty  <= (r_occ == '0);
            r_res_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_idx <= '0;
            r_op  <= fmtf_pkg::OP_ENQ;
        end else begin
            r_occ <= n_occ;
            r_idx <= n_idx;
            if (i_cmd.cap) begin
                r_op <= i_op;
            end
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.empty    = (r_occ == '0);
    assign o_sts.full     = (r_occ == CW'(DEPTH));
    assign o_sts.one      = (r_occ == CW'(1));
    assign o_sts.match    = (r_rd_data == r_key);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.idx_last = ((CW'(r_idx) + CW'(1)) == r_occ);

    assign o_front_value = r_res_front;
    assign o_count       = r_res_count;
    assign o_is_empty    = r_res_empty;
    assign o_status      = r_res_status;

endmodule

// ===== hw/rtl/fmtf_ctrl.sv =====
`timescale 1ns / 1ps
`include "fifo_with_move_to_front_top_macros.svh"

module fmtf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  fmtf_pkg::t_sts i_sts,
    output fmtf_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SEARCH   = 3'd2;
    localparam logic [2:0] S_SHIFT_DN = 3'd3;
    localparam logic [2:0] S_SHIFT_UP = 3'd4;
    localparam logic [2:0] S_WR_FRONT = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [fmtf_pkg::STATUS_W-1:0] r_status;
    logic [fmtf_pkg::STATUS_W-1:0] n_status;
    logic                          r_out_valid;
    logic                          n_out_valid;

    always_comb begin
        n_state        = r_state;
        n_status       = r_status;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.idx_op   = fmtf_pkg::IDX_HOLD;
        o_cmd.wr_op    = fmtf_pkg::WR_NONE;
        o_cmd.status   = r_status;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = fmtf_pkg::ST_OK;
                n_state  = S_FINISH;
                case (i_sts.op)
                    fmtf_pkg::OP_ENQ: begin
                        if (i_sts.full) begin
                            n_status = fmtf_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_op = fmtf_pkg::WR_ENQ;
                        end
                    end
                    fmtf_pkg::OP_DEQ: begin
                        if (i_sts.empty) begin
                            n_status = fmtf_pkg::ST_EMPTY;
                        end else if (i_sts.one) begin
                            o_cmd.occ_dec = 1'b1;
                        end else begin
                            o_cmd.idx_op = fmtf_pkg::IDX_ONE;
                            n_state      = S_SHIFT_DN;
                        end
                    end
                    fmtf_pkg::OP_MTF: begin
                        if (i_sts.empty) begin
                            n_status = fmtf_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.idx_op = fmtf_pkg::IDX_ZERO;
                            n_state      = S_SEARCH;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SEARCH: begin
                if (i_sts.match) begin
                    if (i_sts.idx_zero) begin
                        n_state = S_FINISH;
                    end else begin
                        // fetch the entry ahead of the hit, hit slot is overwritten first
                        o_cmd.idx_op = fmtf_pkg::IDX_DEC;
                        n_state      = S_SHIFT_UP;
                    end
                end else if (i_sts.idx_last) begin
                    n_status = fmtf_pkg::ST_MISSING;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.idx_op = fmtf_pkg::IDX_INC;
                end
            end
            S_SHIFT_DN: begin
                o_cmd.wr_op = fmtf_pkg::WR_DN;
                if (i_sts.idx_last) begin
                    o_cmd.occ_dec = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.idx_op = fmtf_pkg::IDX_INC;
                end
            end
            S_SHIFT_UP: begin
                o_cmd.wr_op = fmtf_pkg::WR_UP;
                if (i_sts.idx_zero) begin
                    n_state = S_WR_FRONT;
                end else begin
                    o_cmd.idx_op = fmtf_pkg::IDX_DEC;
                end
            end
            S_WR_FRONT: begin
                // key equals the matched word, so it goes to the front
                o_cmd.wr_op = fmtf_pkg::WR_FRONT;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= fmtf_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `FMTF_ASSERT_NEXT(a_accept_decode, i_in_valid && o_in_ready, r_state == S_DECODE, "accepted word not decoded")
    `FMTF_ASSERT_NOW(a_full_only_when_full, o_cmd.load_out && r_status == fmtf_pkg::ST_FULL, i_sts.full, "full status with room left")
    `FMTF_ASSERT_NOW(a_shift_needs_entries, r_state == S_SHIFT_DN || r_state == S_SHIFT_UP, !i_sts.empty, "shift on empty queue")
    `FMTF_ASSERT_NEXT(a_result_presented, o_cmd.load_out, r_out_valid, "loaded result not presented")

endmodule

// ===== hw/rtl/fifo_with_move_to_front_top.sv =====
`timescale 1ns / 1ps
// channel  | dir | handshake     | payload
// i_cmd    | in  | valid / ready | op, value
// o_res    | out | valid / ready | front_value, count, is_empty, status
//
// one command at a time; a word is taken only while the sequencer is idle
// enqueue, spare op and any command on an empty queue go straight to the result;
// dequeue shifts entries down; move-to-front searches from the front and, on a hit
// past the front, shifts the entries ahead up and then writes the key to the front
// reset (i_rst_n low, synchronous) empties the queue; no clearing pass
// the result register frees the input side while o_res stalls

module fifo_with_move_to_front_top #(
    parameter int DEPTH      = fmtf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fmtf_pkg::DATA_WIDTH_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    fmtf_in_if.sink     i_cmd,
    fmtf_out_if.source  o_res
);

    fmtf_pkg::t_cmd cmd;
    fmtf_pkg::t_sts sts;

    fmtf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fmtf_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_cmd.op),
        .i_value       (i_cmd.value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_front_value (o_res.front_value),
        .o_count       (o_res.count),
        .o_is_empty    (o_res.is_empty),
        .o_status      (o_res.status)
    );

endmodule
